/* rtl/tdpt_pkg.sv */
// Shared types for the trial division prime test block.
package tdpt_pkg;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  // Status returned by the shared divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

/* rtl/tdpt_if.sv */
// Valid/ready channel interfaces for the candidate input and the verdict output.

// Input channel: one candidate number per item.
interface tdpt_in_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

// Output channel: the verdict and the echoed number per item.
interface tdpt_out_if #(
  parameter int W = 32
) ();
  logic                valid;
  logic                ready;
  logic                is_prime;
  logic signed [W-1:0] tested_value;

  modport source (output valid, output is_prime, output tested_value, input ready);
  modport sink   (input valid, input is_prime, input tested_value, output ready);
endinterface

/* rtl/tdpt_divider.sv */
// Shared restoring divider: one quotient bit per cycle, unsigned operands.
module tdpt_divider #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tdpt_pkg::div_ctl_t  ctl,
  input  logic [WIDTH-1:0]    dividend,
  input  logic [WIDTH-1:0]    divisor,
  output tdpt_pkg::div_sts_t  sts,
  output logic [WIDTH-1:0]    quotient,
  output logic [WIDTH-1:0]    remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] quo_r, quo_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [WIDTH-1:0] dsr_r, dsr_nxt;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign shifted = {rem_r, quo_r[WIDTH-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = (shifted >= {1'b0, dsr_r});

  // Step sequencing.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(WIDTH);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[WIDTH-2:0], fits};
      rem_nxt = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

/* rtl/trial_division_prime_test.sv */
// Top level of the trial division prime test: sequencer around a shared divider.
//
//   channel  | direction | payload                         | handshake
//   ---------+-----------+---------------------------------+------------
//   in_ch    | in        | candidate (signed WIDTH)        | valid/ready
//   out_ch   | out       | is_prime, tested_value (WIDTH)  | valid/ready
//
// Each trial divisor d is one run of the shared restoring divider (a start,
// WIDTH bit steps, then an evaluation of the result); the divider gives
// n/d and n%d together, so the bound d <= n/d and the exact-divisor test share
// one division. Negative n and n <= 1 skip the divider; otherwise divisors are
// tried from 2 upward until d passes n/d or divides n, so a prime n tries the
// most divisors, floor(sqrt(n)) of them.
// Reset is synchronous and active low; nothing is kept between items.
// in_ch.ready is high only while no item is in work; a waiting result
// holds in the output register until out_ch.ready takes it.
module trial_division_prime_test #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  tdpt_in_if.sink          in_ch,
  tdpt_out_if.source       out_ch
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  localparam logic [WIDTH-1:0] FIRST_DIVISOR = WIDTH'(2);

  logic [1:0]       state_r, state_nxt;
  logic [WIDTH-1:0] cand_r, cand_nxt;
  logic [WIDTH-1:0] dvs_r, dvs_nxt;
  logic             verdict_r, verdict_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_prime_r;
  logic [WIDTH-1:0] out_value_r;

  tdpt_pkg::div_ctl_t div_ctl;
  tdpt_pkg::div_sts_t div_sts;
  logic [WIDTH-1:0]   quo;
  logic [WIDTH-1:0]   rem;

  logic in_acc;
  logic trivial;
  logic slot_free;
  logic load_out;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Negative numbers, zero and one are never prime.
  assign trivial   = in_ch.candidate[WIDTH-1] || (in_ch.candidate[WIDTH-1:1] == '0);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign load_out  = (state_r == ST_HOLD) && slot_free;

  // Shared divider: dividend is the candidate, divisor the current trial.
  tdpt_divider #(
    .WIDTH (WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (cand_r),
    .divisor   (dvs_r),
    .sts       (div_sts),
    .quotient  (quo),
    .remainder (rem)
  );

  assign div_ctl.start = (state_r == ST_START);

  // Sequencer over trial divisors.
  always_comb begin
    state_nxt   = state_r;
    cand_nxt    = cand_r;
    dvs_nxt     = dvs_r;
    verdict_nxt = verdict_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cand_nxt = in_ch.candidate;
          dvs_nxt  = FIRST_DIVISOR;
          if (trivial) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_HOLD;
          end else begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_sts.done) begin
          if (dvs_r > quo) begin
            // Divisor passed the square root with no exact divisor found.
            verdict_nxt = 1'b1;
            state_nxt   = ST_HOLD;
          end else if (rem == '0) begin
            verdict_nxt = 1'b0;
            state_nxt   = ST_HOLD;
          end else begin
            dvs_nxt   = dvs_r + WIDTH'(1);
            state_nxt = ST_START;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cand_r    <= cand_nxt;
    dvs_r     <= dvs_nxt;
    verdict_r <= verdict_nxt;
    if (load_out) begin
      out_prime_r <= verdict_r;
      out_value_r <= cand_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_prime     = out_prime_r;
  assign out_ch.tested_value = out_value_r;

endmodule

/* rtl/tdpt_checker.sv */
// Port-level checks for the trial division prime test, bound to the top level.
module tdpt_checker #(
  parameter int WIDTH = 32
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_is_prime,
  input logic [WIDTH-1:0] out_tested_value
);

  // A result that waits is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // The block is busy in the cycle after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while previous one still in work");

  // Negative numbers, zero and one are reported as not prime.
  a_small_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_tested_value[WIDTH-1] || (out_tested_value[WIDTH-1:1] == '0))
    |-> !out_is_prime)
    else $error("value below two reported prime");

  // Even numbers other than two are not prime, and two is.
  a_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tested_value[0] && !out_tested_value[WIDTH-1]
    |-> (out_is_prime == (out_tested_value == WIDTH'(2))))
    else $error("wrong verdict on an even number");

endmodule

bind trial_division_prime_test tdpt_checker #(
  .WIDTH (WIDTH)
) u_tdpt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_is_prime     (out_ch.is_prime),
  .out_tested_value (out_ch.tested_value)
);
